FILE: sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; the macros expect signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked property, masked during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also active during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: sv/lppd_pkg.sv
// Package for the length-prefixed packet deframer: types and constants.
// No dependencies.
package lppd_pkg;

  localparam logic [3:0] HDR_BYTES = 4'd8;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd68;   // 'D'
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd67;   // 'C'
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd1016;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_BAD_SIG  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [23:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [23:0] frame_type;
    logic [23:0] frame_length;
    logic        is_last;
  } result_t;

endpackage

FILE: sv/lppd_if.sv
// Channel interfaces of the deframer: received bytes, results, config writes.
// No dependencies.
interface lppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface lppd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [23:0] frame_type;
  logic [23:0] frame_length;
  logic        is_last;
  modport source (output valid, kind, data_byte, frame_type, frame_length, is_last,
                  input ready);
  modport sink (input valid, kind, data_byte, frame_type, frame_length, is_last,
                output ready);
endinterface

interface lppd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lppd_cfg.sv
// Configuration registers: signature bytes and payload length limit.
// Depends on lppd_pkg and lppd_cfg_if.
module lppd_cfg
  import lppd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lppd_cfg_if.sink      cfg,
  output cfg_t          regs
);

  // writes are refused while reset holds the registers at their defaults
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_first  <= SYNC_FIRST_RST;
      regs.sync_second <= SYNC_SECOND_RST;
      regs.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SYNC_FIRST:  regs.sync_first  <= cfg.data[7:0];
        CFG_SYNC_SECOND: regs.sync_second <= cfg.data[7:0];
        CFG_MAX_PAYLOAD: regs.max_payload <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

FILE: sv/lppd_parse.sv
// Byte parser: header capture, checks, payload counting, result generation.
// Depends on lppd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lppd_parse
  import lppd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       regs,
  output logic       res_valid,
  output result_t    res
);

  logic [3:0]  header_count, header_count_next;
  logic [7:0]  sig_byte_a, sig_byte_a_next;
  logic [7:0]  sig_byte_b, sig_byte_b_next;
  logic [23:0] length_reg, length_reg_next;
  logic [23:0] type_reg, type_reg_next;
  logic [23:0] payload_count, payload_count_next;
  logic        halted, halted_next;
  logic [3:0]  hc_inc;
  logic [23:0] pc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      sig_byte_a    <= '0;
      sig_byte_b    <= '0;
      length_reg    <= '0;
      type_reg      <= '0;
      payload_count <= '0;
      halted        <= 1'b0;
    end else begin
      header_count  <= header_count_next;
      sig_byte_a    <= sig_byte_a_next;
      sig_byte_b    <= sig_byte_b_next;
      length_reg    <= length_reg_next;
      type_reg      <= type_reg_next;
      payload_count <= payload_count_next;
      halted        <= halted_next;
    end
  end

  assign hc_inc = header_count + 4'd1;
  assign pc_inc = payload_count + 24'd1;

  always_comb begin
    header_count_next  = header_count;
    sig_byte_a_next    = sig_byte_a;
    sig_byte_b_next    = sig_byte_b;
    length_reg_next    = length_reg;
    type_reg_next      = type_reg;
    payload_count_next = payload_count;
    halted_next        = halted;
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.frame_type     = type_reg;
    res.frame_length   = length_reg;
    res.is_last        = 1'b0;

    if (accept && !halted) begin
      if (header_count < HDR_BYTES) begin
        unique case (header_count)
          4'd0: sig_byte_a_next = rx_byte;
          4'd1: sig_byte_b_next = rx_byte;
          4'd2: length_reg_next[7:0]   = rx_byte;
          4'd3: length_reg_next[15:8]  = rx_byte;
          4'd4: length_reg_next[23:16] = rx_byte;
          4'd5: type_reg_next[7:0]     = rx_byte;
          4'd6: type_reg_next[15:8]    = rx_byte;
          4'd7: type_reg_next[23:16]   = rx_byte;
          default: ;
        endcase
        header_count_next = hc_inc;
        if (hc_inc == HDR_BYTES) begin
          res.frame_type = type_reg_next;
          priority if (sig_byte_a != regs.sync_first || sig_byte_b != regs.sync_second) begin
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_BAD_SIG;
            res.is_last = 1'b1;
          end else if (length_reg > regs.max_payload) begin
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_TOO_LONG;
            res.is_last = 1'b1;
          end else begin
            payload_count_next = '0;
            if (length_reg == 24'd0) begin
              header_count_next = '0;
              res_valid         = 1'b1;
              res.kind          = KIND_EMPTY;
              res.is_last       = 1'b1;
            end
          end
        end
      end else begin
        payload_count_next = pc_inc;
        res_valid          = 1'b1;
        res.data_byte      = rx_byte;
        if (pc_inc >= length_reg) begin
          res.is_last       = 1'b1;
          header_count_next = '0;
        end
      end
    end
  end

  `ASSERT_CLK(a_halt_sticks, halted |=> halted, "halted state cleared without reset")
  `ASSERT_CLK(a_quiet_when_halted, halted |-> !res_valid, "result produced while halted")
  `ASSERT_CLK(a_error_halts, res_valid && (res.kind == KIND_BAD_SIG || res.kind == KIND_TOO_LONG) |=> halted, "error result did not halt")
  `ASSERT_CLK(a_data_after_header, res_valid && res.kind == KIND_DATA |-> header_count == HDR_BYTES, "payload byte before header complete")

endmodule

FILE: sv/lppd_out_reg.sv
// Result register: holds one result until the sink takes it.
// Depends on lppd_pkg, lppd_result_if and assert_macros.svh.
`include "assert_macros.svh"
module lppd_out_reg
  import lppd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  result_t        din,
  output logic           free,
  lppd_result_if.source  res
);

  logic    valid;
  result_t hold;

  // slot is free when empty or draining this cycle
  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= din;
    end
  end

  assign res.valid        = valid;
  assign res.kind         = hold.kind;
  assign res.data_byte    = hold.data_byte;
  assign res.frame_type   = hold.frame_type;
  assign res.frame_length = hold.frame_length;
  assign res.is_last      = hold.is_last;

  `ASSERT_CLK(a_load_shows, load |=> valid, "loaded result not presented")
  `ASSERT_CLK(a_load_needs_slot, load |-> free, "result loaded into occupied slot")
  `ASSERT_CLK(a_drain_empties, valid && res.ready && !load |=> !valid, "taken result presented twice")

endmodule

FILE: sv/length_prefixed_packet_deframer_top.sv
// Length-prefixed packet deframer, top level.
// Results are registered: a result appears on res in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register sets it, and rx stalls
//   only during reset or while that register holds a result the sink has not taken.
// Reset (rst, synchronous, active high): config returns to 'D', 'C', 1016; parser
//   state clears to the start of a header and leaves the halted state.

module length_prefixed_packet_deframer_top
  import lppd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lppd_byte_if.sink     rx,
  lppd_result_if.source res,
  lppd_cfg_if.sink      cfg
);

  cfg_t    regs;
  result_t parsed;
  logic    parsed_valid;
  logic    slot_free;
  logic    accept;

  // Bytes are taken whenever the result slot can absorb a new result. Header
  // bytes 1-7 and bytes seen while halted produce nothing but still need a free
  // slot, which keeps the ready path simple. Nothing is taken while reset is held.
  assign rx.ready = slot_free && !rst;
  assign accept   = rx.valid && rx.ready;

  // Config writes are taken whenever out of reset; writes must only be issued while idle; not enforced.
  lppd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Header capture, signature/length checks, payload counting. The checks use
  // the register values at the moment the eighth header byte arrives.
  lppd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .regs      (regs),
    .res_valid (parsed_valid),
    .res       (parsed)
  );

  // Output register separates the parser from the result sink.
  lppd_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (parsed_valid),
    .din  (parsed),
    .free (slot_free),
    .res  (res)
  );

endmodule
